// ===== rtl/mpwf_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwf_pkg
// Shared types and constants for the median pick window filter: window
// depth, counter widths, register indexes and the beat payload structs.
// ----------------------------------------------------------------------------
package mpwf_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int REG_W      = 5;
   localparam int CMP_W      = (CNT_W > REG_W) ? CNT_W : REG_W;
   localparam int CSR_IDX_W  = 4;
   localparam int OFF_W      = 48;
   localparam int TAG_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PICK_COUNT  = CSR_IDX_W'(1);

   localparam logic [REG_W-1:0] WINDOW_SIZE_RESET = REG_W'(8);
   localparam logic [REG_W-1:0] PICK_COUNT_RESET  = REG_W'(1);

   typedef struct packed {
      logic signed [OFF_W-1:0] sample_offset;
      logic        [TAG_W-1:0] sample_tag;
   } req_payload_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] picked_offset;
      logic        [TAG_W-1:0] picked_tag;
      logic                    last_pick;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic             insert;
      logic [CNT_W-1:0] fill;
      logic             emit;
      logic [IDX_W-1:0] idx;
      logic             last;
   } dp_cmd_type;

endpackage

// ===== rtl/mpwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpwf_ctrl
// Controller: configuration registers, window fill count and the pick
// sequencer that walks the ordered window from the median outward.
// ----------------------------------------------------------------------------
module mpwf_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mpwf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mpwf_pkg::REG_W-1:0]       csr_data,
   output mpwf_pkg::dp_cmd_type             cmd
);
   import mpwf_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_PICK = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [REG_W-1:0] window_size_ff, window_size_in;
   logic [REG_W-1:0] pick_count_ff, pick_count_in;

   logic             accept;
   logic [CMP_W-1:0] eff_window;
   logic [CMP_W-1:0] fill_next;
   logic             round_start;
   logic             emit_now;
   logic             last_now;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff == ST_PICK);
   assign accept    = start && !busy;

   always_comb begin
      window_size_in = window_size_ff;
      pick_count_in  = pick_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: window_size_in = csr_data;
            CSR_PICK_COUNT:  pick_count_in  = csr_data;
            default: ;
         endcase
      end
   end

   // clamp the window size into 1..MAX_WINDOW
   always_comb begin
      eff_window = CMP_W'(window_size_ff);
      if (eff_window == '0)
         eff_window = CMP_W'(1);
      if (eff_window > CMP_W'(MAX_WINDOW))
         eff_window = CMP_W'(MAX_WINDOW);
   end

   assign fill_next   = CMP_W'(fill_ff) + CMP_W'(1);
   assign round_start = (fill_next >= eff_window);

   assign emit_now = (CMP_W'(k_ff) < CMP_W'(pick_count_ff)) && (n_ff > CNT_W'(2));
   assign last_now = !((CMP_W'(k_ff) + CMP_W'(1) < CMP_W'(pick_count_ff))
                       && (n_ff > CNT_W'(3)));

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = CNT_W'(fill_next);
               if (round_start) begin
                  state_in = ST_PICK;
                  n_in     = CNT_W'(fill_next);
                  k_in     = '0;
               end
            end
         end
         ST_PICK: begin
            if (emit_now) begin
               n_in = n_ff - CNT_W'(1);
               k_in = k_ff + CNT_W'(1);
            end
            // drop the remainder once the round is over
            if (!emit_now || last_now) begin
               state_in = ST_IDLE;
               fill_in  = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.insert = accept;
      cmd.fill   = fill_ff;
      cmd.emit   = busy && emit_now;
      cmd.idx    = IDX_W'(n_ff >> 1);
      cmd.last   = last_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_ff        <= '0;
         n_ff           <= '0;
         k_ff           <= '0;
         window_size_ff <= WINDOW_SIZE_RESET;
         pick_count_ff  <= PICK_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         n_ff           <= n_in;
         k_ff           <= k_in;
         window_size_ff <= window_size_in;
         pick_count_ff  <= pick_count_in;
      end
   end

   a_round_enters_pick: assert property (@(posedge clock) disable iff (reset)
      (accept && round_start) |=> (state_ff == ST_PICK))
      else $error("round did not start after window filled");

   a_emit_needs_three: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (n_ff > CNT_W'(2)))
      else $error("pick issued with two or fewer samples held");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE && fill_ff == '0))
      else $error("window not cleared after final pick");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < CNT_W'(MAX_WINDOW)))
      else $error("fill count reached window depth while idle");

endmodule

// ===== rtl/mpwf_datapath.sv =====
// ----------------------------------------------------------------------------
// mpwf_datapath
// Ordered window as a row of cells: stable sorted insertion of one sample
// per beat, removal of the picked entry, and the registered result port.
// ----------------------------------------------------------------------------
module mpwf_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mpwf_pkg::dp_cmd_type       cmd,
   input  mpwf_pkg::req_payload_type  req_payload,
   output logic                       rsp_strobe,
   output mpwf_pkg::rsp_payload_type  rsp_payload
);
   import mpwf_pkg::*;

   req_payload_type cell_ff [MAX_WINDOW];
   req_payload_type cell_in [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] gt;
   logic [MAX_WINDOW-1:0] prev_gt;
   req_payload_type picked;
   logic            strobe_ff;
   rsp_payload_type rsp_ff, rsp_in;

   // each cell compares its own entry against the incoming key
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         gt[i] = (CNT_W'(i) < cmd.fill)
                 && (cell_ff[i].sample_offset > req_payload.sample_offset);
      end
   end

   assign prev_gt = {gt[MAX_WINDOW-2:0], 1'b0};
   assign picked  = cell_ff[cmd.idx];

   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if ((CNT_W'(i) < cmd.fill) && !gt[i])
               cell_in[i] = cell_ff[i];
            else if (!prev_gt[i])
               cell_in[i] = req_payload;
            else
               cell_in[i] = cell_ff[(i == 0) ? 0 : i - 1];
         end else if (cmd.emit) begin
            // close the gap left by the picked entry
            if ((IDX_W'(i) >= cmd.idx) && (i < MAX_WINDOW - 1))
               cell_in[i] = cell_ff[(i < MAX_WINDOW - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      rsp_in.picked_offset = picked.sample_offset;
      rsp_in.picked_tag    = picked.sample_tag;
      rsp_in.last_pick     = cmd.last;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_WINDOW; i++)
         cell_ff[i] <= cell_in[i];
      if (cmd.emit)
         rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   a_no_insert_during_pick: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !cmd.emit)
      else $error("insert and pick in the same cycle");

   a_strobe_follows_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_strobe)
      else $error("result beat missing after pick");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (CNT_W'(cmd.idx) < CNT_W'(MAX_WINDOW)))
      else $error("pick index beyond window");

endmodule

// ===== rtl/median_pick_window_filter_core.sv =====
// ----------------------------------------------------------------------------
// median_pick_window_filter_core
// Collects tagged offset samples into an ordered window and emits picks
// from the median outward once the window is full.
// ----------------------------------------------------------------------------
// A sample is taken when start is high while busy is low, and is sorted
// into a row of compare cells; equal offsets keep arrival order. The sample
// that fills the window raises busy while its round of P picks runs, where P
// is at most pick_count and no pick is made once two samples remain; the
// pick sequencer removes one entry per cycle. Each result beat shows on
// rsp_payload for one cycle under rsp_strobe, in the cycle after its pick,
// and the final beat of a round has last_pick set. Results cannot be
// stalled. Configuration writes are always ready and belong in idle periods.
module median_pick_window_filter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mpwf_pkg::req_payload_type        req_payload,
   output logic                             rsp_strobe,
   output mpwf_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mpwf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mpwf_pkg::REG_W-1:0]       csr_data
);
   import mpwf_pkg::*;

   dp_cmd_type cmd;

   mpwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd)
   );

   mpwf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
